### rtl/assert_macros.svh
// Assertion macros shared by the selector RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("same-cycle implication violated");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle implication violated");

`endif

### rtl/egs_pkg.sv
// Shared types and constants for the epsilon-greedy selector.
// Used by the controller, the datapath and the top level.
package egs_pkg;

  localparam int DEF_MAX_CHOICES = 16;
  localparam int DEF_REWARD_BITS = 16;

  localparam int REWARD_IN_W = 16;
  localparam int FRAC_W      = 17;
  localparam int INDEX_OUT_W = 4;
  localparam int S_TDATA_W   = 56;
  localparam int M_TDATA_W   = 8;
  localparam int M_TUSER_W   = 2;

  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_SELECT = 1'b1
  } req_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;        // append one reward
    logic select;      // capture round, end it
    logic mul;         // form the roulette target
    logic walk;        // step through prefix sums
    logic out_direct;  // result from empty or greedy select
    logic out_walk;    // result from roulette walk
  } egs_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic empty;   // no entries this round
    logic greedy;  // dice at or below threshold
    logic hit;     // current prefix sum reaches the target, or last entry
  } egs_status_t;

endpackage

### rtl/egs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module egs_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/egs_ctrl.sv
// Controller state machine of the selector: handshakes and sequencing.
// Depends on egs_pkg.
module egs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                req_type,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  egs_pkg::egs_status_t status,
  output egs_pkg::egs_cmd_t    cmd
);

  import egs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_WALK = 3'b100
  } state_t;

  state_t state, state_next;
  logic   m_tvalid_next;
  logic   accept;

  // Idle, and the output register is free or is being emptied this cycle.
  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req_t'(req_type) == REQ_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.select = 1'b1;
            if (status.empty || status.greedy) begin
              cmd.out_direct = 1'b1;
            end else begin
              state_next = ST_MUL;
            end
          end
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (status.hit) begin
          cmd.out_walk = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_direct || cmd.out_walk) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

### rtl/egs_datapath.sv
// Datapath of the selector: round bookkeeping, prefix-sum RAM, target
// multiplier, walk compare and result register. Depends on egs_pkg, egs_ram.
module egs_datapath #(
  parameter int MAX_CHOICES = 16,
  parameter int REWARD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [egs_pkg::FRAC_W-1:0]          cfg_wdata,
  input  logic [egs_pkg::REWARD_IN_W-1:0]     reward,
  input  logic [egs_pkg::FRAC_W-1:0]          dice,
  input  logic [egs_pkg::FRAC_W-1:0]          spin,
  input  egs_pkg::egs_cmd_t                   cmd,
  output egs_pkg::egs_status_t                status,
  output logic [egs_pkg::INDEX_OUT_W-1:0]     out_index,
  output logic                                out_none,
  output logic                                out_ovf
);

  import egs_pkg::*;

  localparam int IDX_W = $clog2(MAX_CHOICES);
  localparam int CNT_W = $clog2(MAX_CHOICES + 1);
  localparam int SUM_W = REWARD_BITS + IDX_W;
  localparam int PRD_W = SUM_W + FRAC_W;

  logic [FRAC_W-1:0]      greedy_threshold;
  logic [CNT_W-1:0]       entry_count;
  logic [SUM_W-1:0]       total;
  logic [IDX_W-1:0]       best_index;
  logic [REWARD_BITS-1:0] best_reward;
  logic                   overflow_seen;

  logic [IDX_W-1:0]       last_idx;
  logic                   round_ovf;
  logic [FRAC_W-1:0]      spin_sat;
  logic [SUM_W-1:0]       target;
  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       data_idx;
  logic [SUM_W-1:0]       rd_data;

  logic [REWARD_BITS-1:0] r;
  logic                   count_full;
  logic                   write_en;
  logic [SUM_W-1:0]       new_sum;
  logic [PRD_W-1:0]       product;

  assign r          = REWARD_BITS'(reward);
  assign count_full = (entry_count == CNT_W'(MAX_CHOICES));
  assign write_en   = cmd.load && !count_full;
  assign new_sum    = ((entry_count == '0) ? '0 : total) + SUM_W'(r);
  assign product    = PRD_W'(total) * PRD_W'(spin_sat);

  assign status.empty  = (entry_count == '0);
  assign status.greedy = (dice <= greedy_threshold);
  // Prefix sums never decrease and the target never exceeds the total,
  // so the last entry always ends the walk.
  assign status.hit    = (target <= rd_data) || (data_idx == last_idx);

  egs_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_CHOICES)
  ) u_prefix_ram (
    .clk   (clk),
    .we    (write_en),
    .waddr (entry_count[IDX_W-1:0]),
    .wdata (new_sum),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      greedy_threshold <= '0;
      entry_count      <= '0;
      best_index       <= '0;
      best_reward      <= '0;
      overflow_seen    <= 1'b0;
    end else begin
      if (cfg_we) begin
        greedy_threshold <= cfg_wdata;
      end
      if (cmd.select) begin
        entry_count   <= '0;
        best_index    <= '0;
        best_reward   <= '0;
        overflow_seen <= 1'b0;
      end else if (cmd.load) begin
        if (count_full) begin
          overflow_seen <= 1'b1;
        end else begin
          entry_count <= entry_count + 1'b1;
          if ((entry_count == '0) || (r > best_reward)) begin
            best_reward <= r;
            best_index  <= entry_count[IDX_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (write_en) begin
      total <= new_sum;
    end
    if (cmd.select) begin
      last_idx  <= IDX_W'(entry_count - 1'b1);
      round_ovf <= overflow_seen;
      spin_sat  <= (spin > FRAC_ONE) ? FRAC_ONE : spin;
      rd_addr   <= '0;
    end else if (cmd.mul || cmd.walk) begin
      rd_addr <= rd_addr + 1'b1;
    end
    if (cmd.mul) begin
      target <= product[PRD_W-FRAC_W+15:16];
    end
    data_idx <= rd_addr;
    if (cmd.out_direct) begin
      out_index <= status.empty ? '0 : INDEX_OUT_W'(best_index);
      out_none  <= status.empty;
      out_ovf   <= overflow_seen;
    end else if (cmd.out_walk) begin
      out_index <= INDEX_OUT_W'(data_idx);
      out_none  <= 1'b0;
      out_ovf   <= round_ovf;
    end
  end

endmodule

### rtl/epsilon_greedy_selector.sv
// Epsilon-greedy selector. A select word whose round is empty or greedy gives
// its result in the next cycle; a roulette select forms the target in a
// multiply state, then reads the prefix-sum RAM entry by entry until the walk
// hits. The input stalls during a walk.
// rst (synchronous) clears the round, the threshold and the output valid.
`include "assert_macros.svh"

module epsilon_greedy_selector #(
  parameter int MAX_CHOICES = egs_pkg::DEF_MAX_CHOICES,
  parameter int REWARD_BITS = egs_pkg::DEF_REWARD_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [egs_pkg::FRAC_W-1:0]       cfg_wdata,   // greedy_threshold
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [egs_pkg::S_TDATA_W-1:0]    s_tdata,     // reward, dice, spin, zero pad
  input  logic                             s_tuser,     // req_type
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [egs_pkg::M_TDATA_W-1:0]    m_tdata,     // chosen_index, zero pad
  output logic [egs_pkg::M_TUSER_W-1:0]    m_tuser      // none_available, load_overflow
);

  import egs_pkg::*;

  egs_cmd_t                 cmd;
  egs_status_t              status;
  logic [INDEX_OUT_W-1:0]   out_index;
  logic                     out_none;
  logic                     out_ovf;

  egs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .req_type (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  egs_datapath #(
    .MAX_CHOICES (MAX_CHOICES),
    .REWARD_BITS (REWARD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .reward    (s_tdata[15:0]),
    .dice      (s_tdata[32:16]),
    .spin      (s_tdata[49:33]),
    .cmd       (cmd),
    .status    (status),
    .out_index (out_index),
    .out_none  (out_none),
    .out_ovf   (out_ovf)
  );

  assign m_tdata = {(M_TDATA_W - INDEX_OUT_W)'(0), out_index};
  assign m_tuser = {out_ovf, out_none};

  // A pending result is never overwritten.
  `ASSERT_IMP(a_no_overwrite, cmd.out_direct || cmd.out_walk, !m_tvalid || m_tready)
  // Load and select never act together.
  `ASSERT_IMP(a_one_request, 1'b1, !(cmd.load && cmd.select))
  // A roulette select holds off the input while it walks.
  `ASSERT_NEXT(a_walk_stalls, cmd.select && !cmd.out_direct, !s_tready && cmd.mul)
  // A walk finishing produces a valid word the next cycle.
  `ASSERT_NEXT(a_walk_result, cmd.out_walk, m_tvalid && !m_tuser[0])

endmodule
